/* sv/best_fit_heap_allocator_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit heap allocator.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BFHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bfha_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_pkg
// Constants, command and status types shared by the heap allocator files.
// ---------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned FIELD_W        = 13;
  localparam int unsigned HEAP_BYTES_DEF = 4096;
  localparam int unsigned HDR_BYTES      = 8;
  localparam int unsigned ALIGN_BYTES    = 16;
  localparam int unsigned SPLIT_MIN      = 16;
  localparam int unsigned END_MARK       = 1;
  localparam int unsigned ALLOC_BIT      = 1;
  localparam int unsigned PREV_BIT       = 2;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_HDR   = 3'd2,
    WR_FTR   = 3'd3,
    WR_REM   = 3'd4,
    WR_RFT   = 3'd5,
    WR_NXT   = 3'd6
  } wr_op_t;

  typedef struct packed {
    logic   load_req;
    logic   walk_step;
    logic   rd_adv;
    logic   rd_nxt;
    logic   clr_step;
    logic   load_out;
    wr_op_t wr_op;
  } bfha_cmd_t;

  typedef struct packed {
    logic req_zero;
    logic walk_stop;
    logic hdr_stop;
    logic next_stop;
    logic found;
    logic split;
    logic nxt_in;
    logic nxt_end;
    logic clr_last;
    logic out_free;
  } bfha_sts_t;

endpackage

/* sv/bfha_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_if
// Request and response channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
interface bfha_req_if import bfha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] request_size;

  modport source (output valid, output request_size, input ready);
  modport sink   (input valid, input request_size, output ready);
endinterface

interface bfha_rsp_if import bfha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [FIELD_W-1:0] payload_offset;
  logic [FIELD_W-1:0] block_size;

  modport source (output valid, output granted, output payload_offset,
                  output block_size, input ready);
  modport sink   (input valid, input granted, input payload_offset,
                  input block_size, output ready);
endinterface

/* sv/bfha_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module bfha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/bfha_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_ctrl
// Sequencer for the heap clear, the header walk and the block update writes.
// ---------------------------------------------------------------------------
module bfha_ctrl import bfha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfha_sts_t sts,
  output bfha_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_WALK_RD  = 12'b0000_0000_0100,
    S_WALK_EV  = 12'b0000_0000_1000,
    S_WALK_END = 12'b0000_0001_0000,
    S_WR_HDR   = 12'b0000_0010_0000,
    S_WR_FTR   = 12'b0000_0100_0000,
    S_WR_REM   = 12'b0000_1000_0000,
    S_WR_RFT   = 12'b0001_0000_0000,
    S_NX_RD    = 12'b0010_0000_0000,
    S_NX_EV    = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wr_op = WR_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_op    = WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = sts.req_zero ? S_RESP : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_nxt = sts.walk_stop ? S_WALK_END : S_WALK_EV;
      end
      S_WALK_EV: begin
        if (sts.hdr_stop) begin
          state_nxt = S_WALK_END;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.rd_adv    = 1'b1;
          if (sts.next_stop) begin
            state_nxt = S_WALK_END;
          end
        end
      end
      S_WALK_END: begin
        state_nxt = sts.found ? S_WR_HDR : S_RESP;
      end
      S_WR_HDR: begin
        cmd.wr_op = WR_HDR;
        state_nxt = S_WR_FTR;
      end
      S_WR_FTR: begin
        cmd.wr_op = WR_FTR;
        if (sts.split) begin
          state_nxt = S_WR_REM;
        end else if (sts.nxt_in) begin
          state_nxt = S_NX_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_WR_REM: begin
        cmd.wr_op = WR_REM;
        state_nxt = S_WR_RFT;
      end
      S_WR_RFT: begin
        cmd.wr_op = WR_RFT;
        state_nxt = S_RESP;
      end
      S_NX_RD: begin
        cmd.rd_nxt = 1'b1;
        state_nxt  = S_NX_EV;
      end
      S_NX_EV: begin
        if (!sts.nxt_end) begin
          cmd.wr_op = WR_NXT;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/bfha_dpath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_dpath
// Header memory, walk registers, best-fit tracking and the response register.
// ---------------------------------------------------------------------------
module bfha_dpath import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bfha_cmd_t          cmd,
  output bfha_sts_t          sts,
  input  logic [FIELD_W-1:0] request_size,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               granted,
  output logic [FIELD_W-1:0] payload_offset,
  output logic [FIELD_W-1:0] block_size
);

  localparam int unsigned SLOTS = HEAP_BYTES / HDR_BYTES;
  localparam int unsigned SAW   = $clog2(SLOTS);
  localparam int unsigned SW    = $clog2(SLOTS + 1);
  localparam int unsigned HW    = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned AW    = HW + 1;
  localparam int unsigned NW    = (AW > FIELD_W + 1) ? AW : FIELD_W + 1;

  localparam logic [HW-1:0] END_H    = HW'(END_MARK);
  localparam logic [HW-1:0] PREV_H   = HW'(PREV_BIT);
  localparam logic [HW-1:0] STAT_H   = HW'(ALLOC_BIT | PREV_BIT);
  localparam logic [HW-1:0] INIT_HDR = HW'(HEAP_BYTES - HDR_BYTES) | PREV_H;
  localparam logic [NW-1:0] HEAP_N   = NW'(HEAP_BYTES);
  localparam logic [NW-1:0] HDR_N    = NW'(HDR_BYTES);

  logic [NW-1:0]      need_r;
  logic [NW-1:0]      off_r;
  logic [SW-1:0]      steps_r;
  logic [NW-1:0]      best_off_r;
  logic [NW-1:0]      best_size_r;
  logic               found_r;
  logic [SAW-1:0]     clr_idx_r;
  logic               out_valid_r;
  logic               granted_r;
  logic [FIELD_W-1:0] payload_offset_r;
  logic [FIELD_W-1:0] block_size_r;

  logic [HW-1:0]  rdata;
  logic [NW-1:0]  need_calc;
  logic [NW-1:0]  sz;
  logic [NW-1:0]  off_next;
  logic [SW-1:0]  steps_next;
  logic           fit;
  logic [NW-1:0]  grant;
  logic [NW-1:0]  rem;
  logic [NW-1:0]  ftr_off;
  logic [NW-1:0]  rem_off;
  logic [NW-1:0]  rft_off;
  logic [NW-1:0]  nxt_off;
  logic [HW-1:0]  clr_word;
  logic           we;
  logic [SAW-1:0] waddr;
  logic [HW-1:0]  wdata;
  logic [SAW-1:0] raddr;

  assign need_calc = (NW'(request_size) + NW'(HDR_BYTES + ALIGN_BYTES - 1))
                     & ~NW'(ALIGN_BYTES - 1);

  assign sz         = NW'({rdata[HW-1:2], 2'b00});
  assign off_next   = off_r + sz;
  assign steps_next = steps_r + SW'(1);
  assign fit        = !rdata[0] && (need_r <= sz) && (!found_r || sz <= best_size_r)
                      && (sz <= HEAP_N - off_r);

  assign rem     = best_size_r - need_r;
  assign grant   = sts.split ? need_r : best_size_r;
  assign ftr_off = best_off_r + grant - HDR_N;
  assign rem_off = best_off_r + need_r;
  assign rft_off = best_off_r + best_size_r - HDR_N;
  assign nxt_off = best_off_r + best_size_r;

  always_comb begin
    sts           = '0;
    sts.req_zero  = (request_size == '0);
    sts.walk_stop = (off_r >= HEAP_N) || (steps_r >= SW'(SLOTS));
    sts.hdr_stop  = (rdata == END_H) || (sz == '0);
    sts.next_stop = (off_next >= HEAP_N) || (steps_next >= SW'(SLOTS));
    sts.found     = found_r;
    sts.split     = (best_size_r - need_r) > NW'(SPLIT_MIN);
    sts.nxt_in    = (nxt_off < HEAP_N);
    sts.nxt_end   = (rdata == END_H);
    sts.clr_last  = (clr_idx_r == SAW'(SLOTS - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    if (clr_idx_r == '0) begin
      clr_word = INIT_HDR;
    end else if (clr_idx_r == SAW'(SLOTS - 1)) begin
      clr_word = END_H;
    end else begin
      clr_word = '0;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = best_off_r[SAW+2:3];
    wdata = HW'(grant) | STAT_H;
    case (cmd.wr_op)
      WR_CLEAR: begin
        waddr = clr_idx_r;
        wdata = clr_word;
      end
      WR_HDR: begin
        waddr = best_off_r[SAW+2:3];
      end
      WR_FTR: begin
        waddr = ftr_off[SAW+2:3];
      end
      WR_REM: begin
        waddr = rem_off[SAW+2:3];
        wdata = HW'(rem) | PREV_H;
      end
      WR_RFT: begin
        waddr = rft_off[SAW+2:3];
        wdata = HW'(rem);
      end
      WR_NXT: begin
        waddr = nxt_off[SAW+2:3];
        wdata = rdata | PREV_H;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.rd_nxt) begin
      raddr = nxt_off[SAW+2:3];
    end else if (cmd.rd_adv) begin
      raddr = off_next[SAW+2:3];
    end else begin
      raddr = off_r[SAW+2:3];
    end
  end

  bfha_ram #(
    .WIDTH (HW),
    .DEPTH (SLOTS)
  ) u_heap_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + SAW'(1);
      end
      if (cmd.load_req) begin
        found_r <= 1'b0;
      end else if (cmd.walk_step && fit) begin
        found_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      need_r  <= need_calc;
      off_r   <= '0;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      off_r   <= off_next;
      steps_r <= steps_next;
      if (fit) begin
        best_off_r  <= off_r;
        best_size_r <= sz;
      end
    end
    if (cmd.load_out) begin
      granted_r        <= found_r;
      payload_offset_r <= found_r ? FIELD_W'(best_off_r + HDR_N) : '0;
      block_size_r     <= found_r ? FIELD_W'(grant) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign granted        = granted_r;
  assign payload_offset = payload_offset_r;
  assign block_size     = block_size_r;

endmodule

/* sv/best_fit_heap_allocator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit allocator over an implicit list of 8-byte block headers.
// ---------------------------------------------------------------------------
//  Channel   Side     Beat contents
//  in_req    sink     request_size
//  out_rsp   source   granted, payload_offset, block_size
//
//  After reset the header memory is cleared, one slot per cycle, through all
//  HEAP_BYTES/8 slots (512 at the default size); no request is taken then.
//  A request walks the headers, one per cycle, counting the end marker; a
//  grant then writes the block header and footer and the split remainder's
//  header and footer, or the next block's header (no writes on a refusal);
//  then the response is loaded. A zero-size request goes straight to it.
//  The response register lets a new request enter while a response is stalled.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_unit import bfha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfha_req_if.sink    in_req,
  bfha_rsp_if.source  out_rsp
);

  bfha_cmd_t cmd;
  bfha_sts_t sts;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfha_dpath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .request_size   (in_req.request_size),
    .out_ready      (out_rsp.ready),
    .out_valid      (out_rsp.valid),
    .granted        (out_rsp.granted),
    .payload_offset (out_rsp.payload_offset),
    .block_size     (out_rsp.block_size)
  );

endmodule

/* sv/bfha_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfha_checker
// Port-level checks on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "best_fit_heap_allocator_unit_assert.svh"

module bfha_checker (
  input logic        clk,
  input logic        rst_n,
  bfha_req_if.sink   in_req,
  bfha_rsp_if.source out_rsp
);

  `BFHA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_rsp.valid && !out_rsp.granted, out_rsp.payload_offset == '0 && out_rsp.block_size == '0, "failed grant carries nonzero fields")
  `BFHA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready, "request accepted while another is in work")
  `BFHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_rsp.valid && !out_rsp.ready, out_rsp.valid && $stable(out_rsp.granted) && $stable(out_rsp.payload_offset) && $stable(out_rsp.block_size), "stalled response beat changed")

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_rsp (out_rsp)
);
